[rtl/mvm_pkg.sv]
// Shared types and constants for the matrix-vector multiply core.
// No dependencies; imported by the core and the testbench.
`default_nettype none

package mvm_pkg;

  // Result accumulator width (Q16.24).
  localparam int DOT_W = 40;
  // Width of the configuration registers and the input index fields.
  localparam int REG_W = 6;
  localparam int IDX_W = 5;
  localparam logic [REG_W-1:0] COUNT_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    CMD_WEIGHT  = 2'd0,
    CMD_VECTOR  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

[rtl/matrix_vector_multiply_core.sv]
// Dense matrix-vector multiply core: Q4.12 weights and vector, Q16.24 row sums.
// Depends on mvm_pkg and mvm_ram.
// A compute runs one shared multiply-accumulate over the columns of each row:
// each row issues its reads, drains the multiply pipeline, then waits for its output transfer,
// and input is not ready until the last row leaves.
// Reset (rst, synchronous) clears control and sets both counts to 32; stores are not cleared.
`default_nettype none

module matrix_vector_multiply_core #(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [mvm_pkg::REG_W-1:0]        cfg_data,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [4:0] row_index, [9:5] col_index, [9+VALUE_BITS:10] value, zero fill above
  input  wire logic [((2*mvm_pkg::IDX_W+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [1:0] cmd
  input  wire logic [1:0]                       s_axis_tuser,
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [4:0] out_row, [44:5] dot_value, [47:45] zero
  output logic [47:0]                           m_axis_tdata,
  // last_row
  output logic                                  m_axis_tlast
);

  import mvm_pkg::*;

  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int CA     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NRW    = $clog2(MAX_ROWS + 1);
  localparam int NCW    = $clog2(MAX_COLS + 1);
  localparam int PW     = 2 * VALUE_BITS;
  localparam int EW     = (PW > DOT_W) ? PW : DOT_W;
  localparam int VLO    = 2 * IDX_W;

  // input field views
  logic [IDX_W-1:0]      in_row;
  logic [IDX_W-1:0]      in_col;
  logic [VALUE_BITS-1:0] in_value;
  cmd_t                  in_cmd;
  logic                  in_xfer;

  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[VLO-1:IDX_W];
  assign in_value = s_axis_tdata[VLO+VALUE_BITS-1:VLO];
  assign in_cmd   = cmd_t'(s_axis_tuser);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // configuration registers
  logic [REG_W-1:0] rows_in_use;
  logic [REG_W-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= COUNT_RESET;
      cols_in_use <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
      endcase
    end
  end

  // sequencer and datapath registers
  state_t                  state;
  state_t                  state_next;
  logic [NRW-1:0]          n_rows;
  logic [NCW-1:0]          n_cols;
  logic [NRW-1:0]          row_cnt;
  logic [NCW-1:0]          col_cnt;
  logic [WA-1:0]           row_base;
  logic                    rd_v;
  logic                    rd_last;
  logic                    prod_v;
  logic                    prod_last;
  logic signed [PW-1:0]    prod;
  logic [DOT_W-1:0]        acc;
  logic [DOT_W-1:0]        out_dot;
  logic [IDX_W-1:0]        out_row;
  logic                    out_last;

  // control decodes
  logic                    issue;
  logic                    issue_last;
  logic                    row_done;
  logic                    out_xfer;
  logic                    start;
  logic                    last_row_now;
  logic [NRW-1:0]          rows_clamped;
  logic [NCW-1:0]          cols_clamped;

  // store ports
  logic                    w_we;
  logic                    v_we;
  logic [WA-1:0]           w_waddr;
  logic [WA-1:0]           w_raddr;
  logic [VALUE_BITS-1:0]   w_rdata;
  logic [VALUE_BITS-1:0]   v_rdata;
  logic signed [EW-1:0]    prod_wide;
  logic [DOT_W-1:0]        acc_sum;

  always_comb begin
    if (rows_in_use == '0) begin
      rows_clamped = NRW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows_clamped = NRW'(MAX_ROWS);
    end else begin
      rows_clamped = NRW'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      cols_clamped = NCW'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      cols_clamped = NCW'(MAX_COLS);
    end else begin
      cols_clamped = NCW'(cols_in_use);
    end
  end

  assign issue_last   = (col_cnt + NCW'(1)) == n_cols;
  assign row_done     = prod_v && prod_last;
  assign out_xfer     = m_axis_tvalid && m_axis_tready;
  assign start        = in_xfer && (in_cmd == CMD_COMPUTE);
  assign last_row_now = (row_cnt + NRW'(1)) == n_rows;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_MAC;
      ST_MAC:   if (issue_last) state_next = ST_DRAIN;
      ST_DRAIN: if (row_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_xfer) state_next = out_last ? ST_IDLE : ST_MAC;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    issue         = 1'b0;
    unique case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_MAC:   issue = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  m_axis_tvalid = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_v    <= 1'b0;
      prod_v  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_v    <= issue;
      prod_v  <= rd_v;
    end
  end

  // counters and address walk
  always_ff @(posedge clk) begin
    if (start) begin
      n_rows   <= rows_clamped;
      n_cols   <= cols_clamped;
      row_cnt  <= '0;
      row_base <= '0;
      col_cnt  <= '0;
    end else if (issue) begin
      col_cnt  <= col_cnt + NCW'(1);
    end else if (out_xfer) begin
      row_cnt  <= row_cnt + NRW'(1);
      row_base <= row_base + WA'(MAX_COLS);
      col_cnt  <= '0;
    end
    rd_last   <= issue_last;
    prod_last <= rd_last;
  end

  // shared multiply-accumulate
  assign prod_wide = EW'(prod);
  assign acc_sum   = acc + prod_wide[DOT_W-1:0];

  always_ff @(posedge clk) begin
    prod <= $signed(w_rdata) * $signed(v_rdata);
    if (start) begin
      acc <= '0;
    end else if (prod_v) begin
      // clear at row end so the next row starts from zero
      acc <= prod_last ? '0 : acc_sum;
    end
    if (row_done) begin
      out_dot  <= acc_sum;
      out_row  <= IDX_W'(row_cnt);
      out_last <= last_row_now;
    end
  end

  assign m_axis_tdata = {3'b000, out_dot, out_row};
  assign m_axis_tlast = out_last;

  // stores
  assign w_we    = in_xfer && (in_cmd == CMD_WEIGHT)
                   && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign v_we    = in_xfer && (in_cmd == CMD_VECTOR) && (32'(in_col) < MAX_COLS);
  assign w_waddr = WA'(32'(in_row) * 32'(MAX_COLS) + 32'(in_col));
  assign w_raddr = row_base + WA'(col_cnt[CA-1:0]);

  mvm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mvm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_vector_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (CA'(in_col)),
    .wdata (in_value),
    .raddr (col_cnt[CA-1:0]),
    .rdata (v_rdata)
  );

  // checks
  a_busy_not_ready : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_emit_pipe_empty : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!rd_v && !prod_v))
    else $error("multiply pipeline busy while a result is shown");

  a_last_returns_idle : assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after the last row transfer");

  a_row_end_in_drain : assert property (@(posedge clk) disable iff (rst)
    row_done |-> (state == ST_DRAIN))
    else $error("row sum completed outside drain");

endmodule

`default_nettype wire

[rtl/mvm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the weight and vector stores.
`default_nettype none

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[tb/tb_matrix_vector_multiply_core.sv]
// Testbench for matrix_vector_multiply_core: weight and vector loads, computes and count limits.
// Depends on mvm_pkg and the core; a built-in fixed-point predictor checks every row result.
module tb_matrix_vector_multiply_core;
  import mvm_pkg::*;

  localparam int TDATA_W       = ((2*IDX_W + 16 + 7)/8)*8;
  localparam int NUM_ROWS      = 32;
  localparam int NUM_COLS      = 32;
  localparam int ITEM_TARGET   = 450;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int IDLE_PCT      = 17;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic signed [DOT_W-1:0] dot;
    logic                    last;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [REG_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = 2'd0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic m_axis_tlast;

  // predictor state
  logic signed [15:0] weight_mem [NUM_ROWS][NUM_COLS];
  logic signed [15:0] vector_mem [NUM_COLS];
  bit                 weight_loaded [NUM_ROWS][NUM_COLS];
  bit                 vector_loaded [NUM_COLS];
  logic [REG_W-1:0]   rows_cfg = COUNT_RESET;
  logic [REG_W-1:0]   cols_cfg = COUNT_RESET;
  row_result_t        rows_due [$];

  int  errors = 0;
  int  inputs_accepted = 0;
  int  computes_sent = 0;
  int  results_checked = 0;
  int  stall_cycles = 0;
  bit  steady = 1'b0;

  matrix_vector_multiply_core DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic int eff_count(logic [REG_W-1:0] count, int limit);
    if (count == 0) return 1;
    if (count > limit) return limit;
    return count;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly land inside the active area, sometimes anywhere.
  function automatic logic [IDX_W-1:0] pick_index(int span);
    if ($urandom_range(99) < 75) return IDX_W'($urandom_range(span - 1));
    return IDX_W'($urandom);
  endfunction

  function automatic logic [REG_W-1:0] random_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return REG_W'($urandom_range(1, 6));
    if (pick < 85) return REG_W'($urandom_range(7, 32));
    if (pick < 95) return '0;
    return REG_W'($urandom_range(33, 63));
  endfunction

  task automatic update_prediction(logic [1:0] cmd, logic [IDX_W-1:0] row,
                                   logic [IDX_W-1:0] col, logic [15:0] value);
    int nr;
    int nc;
    longint acc;
    row_result_t res;
    case (cmd)
      CMD_WEIGHT: begin
        weight_mem[row][col] = value;
        weight_loaded[row][col] = 1'b1;
      end
      CMD_VECTOR: begin
        vector_mem[col] = value;
        vector_loaded[col] = 1'b1;
      end
      CMD_COMPUTE: begin
        nr = eff_count(rows_cfg, NUM_ROWS);
        nc = eff_count(cols_cfg, NUM_COLS);
        for (int i = 0; i < nr; i++) begin
          acc = 0;
          for (int j = 0; j < nc; j++)
            acc += longint'(weight_mem[i][j]) * longint'(vector_mem[j]);
          res.row  = IDX_W'(i);
          res.dot  = acc[DOT_W-1:0];
          res.last = (i == nr - 1);
          rows_due.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] cmd, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [15:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= TDATA_W'({value, col, row});
    do @(posedge clk); while (!s_axis_tready);
    inputs_accepted++;
    if (cmd == CMD_COMPUTE) computes_sent++;
    update_prediction(cmd, row, col, value);
  endtask

  // Hold input off until every row result is back, then let the core settle.
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count_reg(logic idx, logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_ROWS) rows_cfg = data;
    else cols_cfg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Load every entry the next compute reads that has not been loaded yet.
  task automatic fill_active_area();
    int nr;
    int nc;
    nr = eff_count(rows_cfg, NUM_ROWS);
    nc = eff_count(cols_cfg, NUM_COLS);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (!weight_loaded[r][c]) send_item(CMD_WEIGHT, IDX_W'(r), IDX_W'(c), rand_value());
    for (int c = 0; c < nc; c++)
      if (!vector_loaded[c]) send_item(CMD_VECTOR, IDX_W'($urandom), IDX_W'(c), rand_value());
  endtask

  task automatic send_compute();
    send_item(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), 16'($urandom));
  endtask

  task automatic test_directed_values();
    write_count_reg(REG_ROWS, 6'd1);
    write_count_reg(REG_COLS, 6'd1);
    // most negative times most negative
    send_item(CMD_WEIGHT, 5'd0, 5'd0, 16'h8000);
    send_item(CMD_VECTOR, 5'd31, 5'd0, 16'h8000);
    send_compute();
    send_item(CMD_UNUSED, 5'd31, 5'd31, 16'hffff);
    send_item(CMD_VECTOR, 5'd0, 5'd0, 16'h7fff);
    send_compute();
    wait_for_results();
    write_count_reg(REG_ROWS, 6'd2);
    write_count_reg(REG_COLS, 6'd2);
    send_item(CMD_WEIGHT, 5'd0, 5'd1, 16'h7fff);
    send_item(CMD_WEIGHT, 5'd1, 5'd0, 16'hffff);
    send_item(CMD_WEIGHT, 5'd1, 5'd1, 16'h8000);
    send_item(CMD_VECTOR, 5'd0, 5'd1, 16'h7fff);
    send_item(CMD_WEIGHT, 5'd31, 5'd31, 16'h0001);
    send_compute();
    send_item(CMD_WEIGHT, 5'd1, 5'd1, 16'h0000);
    send_item(CMD_UNUSED, 5'd0, 5'd0, 16'h0000);
    send_compute();
  endtask

  task automatic test_count_clamp();
    wait_for_results();
    write_count_reg(REG_ROWS, 6'd63);
    write_count_reg(REG_COLS, 6'd1);
    fill_active_area();
    send_compute();
    wait_for_results();
    write_count_reg(REG_ROWS, 6'd0);
    write_count_reg(REG_COLS, 6'd40);
    fill_active_area();
    send_compute();
    wait_for_results();
    write_count_reg(REG_ROWS, 6'd32);
    write_count_reg(REG_COLS, 6'd0);
    send_compute();
  endtask

  task automatic send_random_item();
    int pick;
    int nr;
    int nc;
    nr = eff_count(rows_cfg, NUM_ROWS);
    nc = eff_count(cols_cfg, NUM_COLS);
    pick = $urandom_range(99);
    if (pick < 35)
      send_item(CMD_WEIGHT, pick_index(nr), pick_index(nc), rand_value());
    else if (pick < 58)
      send_item(CMD_VECTOR, IDX_W'($urandom), pick_index(nc), rand_value());
    else if (pick < 63)
      send_item(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), 16'($urandom));
    else
      send_compute();
  endtask

  task automatic test_random_traffic();
    int phase;
    phase = 0;
    while (inputs_accepted < ITEM_TARGET) begin
      wait_for_results();
      steady = (phase >= 3 && phase < 7);
      write_count_reg(REG_ROWS, random_count());
      write_count_reg(REG_COLS, random_count());
      // keep the load phase bounded on large shapes
      if (eff_count(rows_cfg, NUM_ROWS) * eff_count(cols_cfg, NUM_COLS) > 256)
        write_count_reg(REG_COLS, REG_W'($urandom_range(1, 8)));
      fill_active_area();
      repeat ($urandom_range(6, 20)) send_random_item();
      phase++;
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (rows_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual row %0d dot %0d", $time,
                 m_axis_tdata[4:0], $signed(m_axis_tdata[44:5]));
      end else begin
        want = rows_due.pop_front();
        results_checked++;
        if (m_axis_tdata[4:0] !== want.row) begin
          errors++;
          $display("%0t: out_row mismatch, expected %0d, actual %0d", $time,
                   want.row, m_axis_tdata[4:0]);
        end
        if ($signed(m_axis_tdata[44:5]) !== want.dot) begin
          errors++;
          $display("%0t: dot_value mismatch on row %0d, expected %0d, actual %0d", $time,
                   want.row, want.dot, $signed(m_axis_tdata[44:5]));
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last_row mismatch on row %0d, expected %0b, actual %0b", $time,
                   want.row, want.last, m_axis_tlast);
        end
      end
    end
  end

  // Count cycles with no transfer on either stream.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d row results outstanding", $time,
               STALL_LIMIT, rows_due.size());
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_values();
    test_count_clamp();
    test_random_traffic();
    wait_for_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d input transfers with %0d computes, %0d row results checked",
             inputs_accepted, computes_sent, results_checked);
    $display("counts ran from 1 to 32 plus zero and above-max settings, values at both extremes");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
